// File: sv/osrs_pkg.sv
package osrs_pkg;

   // defaults for the top level parameters
   localparam int MAX_FRAME_BYTES_DEF = 1572864;
   localparam int MAX_FRAMES_DEF      = 4;

   // status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_FRAME_SIZE = 3'd1;
   localparam logic [2:0] ST_COUNT      = 3'd2;
   localparam logic [2:0] ST_NO_MEMORY  = 3'd3;
   localparam logic [2:0] ST_FORMAT     = 3'd4;
   localparam logic [2:0] ST_DIVIDE     = 3'd5;

   // pixel formats
   localparam logic [1:0] FMT_PLANAR = 2'd0;
   localparam logic [1:0] FMT_PACKED = 2'd1;

   // csr indexes
   localparam logic CSR_IS_NEWER_CHIP = 1'b0;
   localparam logic CSR_VIDEO_RAM_MB  = 1'b1;

   // scaler register offsets
   localparam logic [13:0] OFS_CTL        = 14'h3d20;
   localparam logic [13:0] OFS_LUMA_CTL   = 14'h3d40;
   localparam logic [13:0] OFS_PITCH      = 14'h3d24;
   localparam logic [13:0] OFS_ORG_BASE   = 14'h3d00;
   localparam logic [13:0] OFS_CORG_BASE  = 14'h3d10;
   localparam logic [13:0] OFS_C3ORG_BASE = 14'h3d60;
   localparam logic [13:0] OFS_HCOORD     = 14'h3d28;
   localparam logic [13:0] OFS_HISCAL     = 14'h3d30;
   localparam logic [13:0] OFS_HSRCST     = 14'h3d38;
   localparam logic [13:0] OFS_HSRCEND    = 14'h3d3c;
   localparam logic [13:0] OFS_HSRCLST    = 14'h3d50;
   localparam logic [13:0] OFS_VCOORD     = 14'h3d2c;
   localparam logic [13:0] OFS_VISCAL     = 14'h3d34;
   localparam logic [13:0] OFS_V1SRCLST   = 14'h3d54;
   localparam logic [13:0] OFS_V1WGHT     = 14'h3d48;
   localparam logic [13:0] OFS_V2SRCLST   = 14'h3d58;
   localparam logic [13:0] OFS_V2WGHT     = 14'h3d4c;
   localparam logic [13:0] OFS_GLOBAL     = 14'h3dc0;

   localparam logic [31:0] CTL_BASE     = 32'h0005_0c01;
   localparam logic [31:0] CTL_PLANAR   = 32'h0002_0000;
   localparam logic [31:0] LUMA_CTL_VAL = 32'h0000_0080;
   localparam logic [31:0] GLOBAL_BASE  = 32'h0000_00a0;

   // classified request passed from front to back
   typedef struct packed {
      logic [11:0] window_x;
      logic [11:0] window_y;
      logic [10:0] source_width;
      logic [10:0] source_height;
      logic [10:0] scaled_width;
      logic [10:0] scaled_height;
      logic [1:0]  pixel_format;
      logic [20:0] frame_bytes;
      logic [11:0] line_count;
      logic [31:0] base;
      logic [2:0]  status;
   } desc_type;

endpackage

// File: sv/overlay_scaler_register_setup.sv
// a request passes the front hold register and the queue, then the back states PREP,
// WAIT_H, WAIT_V and CALC1 to CALC3 before the first write; an error result leaves from PREP
// the back takes one request at a time, using the shared 32-step divider twice, then sends
// one write per cycle out while not stalled; the front and queue take new requests meanwhile
// reset clears the queue, the sequencer, csrs (older chip, 16 MiB) and chroma origins
module overlay_scaler_register_setup #(
   parameter int MAX_FRAME_BYTES = osrs_pkg::MAX_FRAME_BYTES_DEF,
   parameter int MAX_FRAMES      = osrs_pkg::MAX_FRAMES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // csr write port
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [6:0]         csr_data,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [11:0] req_window_x,
   input  logic signed [11:0] req_window_y,
   input  logic [10:0]        req_source_width,
   input  logic [10:0]        req_source_height,
   input  logic [10:0]        req_scaled_width,
   input  logic [10:0]        req_scaled_height,
   input  logic [1:0]         req_pixel_format,
   input  logic [20:0]        req_frame_bytes,
   input  logic [2:0]         req_frame_count,
   input  logic [11:0]        req_line_count,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [13:0]        rsp_reg_offset,
   output logic [31:0]        rsp_reg_value,
   output logic [2:0]         rsp_status,
   output logic               rsp_last
);

   logic               is_newer_chip_ff, is_newer_chip_in;
   logic [6:0]         video_ram_mb_ff, video_ram_mb_in;

   // front to queue to back
   logic               q_push, q_full, q_pop, q_empty;
   osrs_pkg::desc_type q_push_data, q_pop_data;

   // shared divider
   logic               div_start, div_done;
   logic [31:0]        div_dividend, div_quotient;
   logic [10:0]        div_divisor;

   // csrs, written only while idle: a rule for the user that the block itself does not enforce
   always_comb begin
      is_newer_chip_in = is_newer_chip_ff;
      video_ram_mb_in  = video_ram_mb_ff;
      if (csr_write) begin
         case (csr_index)
            osrs_pkg::CSR_IS_NEWER_CHIP: is_newer_chip_in = csr_data[0];
            osrs_pkg::CSR_VIDEO_RAM_MB:  video_ram_mb_in  = csr_data;
            default: begin
               is_newer_chip_in = is_newer_chip_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_newer_chip_ff <= 1'b0;
         video_ram_mb_ff  <= 7'd16;
      end else begin
         is_newer_chip_ff <= is_newer_chip_in;
         video_ram_mb_ff  <= video_ram_mb_in;
      end
   end

   // front: checks frame size, count, memory fit, format and spans; places buffers
   osrs_front #(
      .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
      .MAX_FRAMES     (MAX_FRAMES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .video_ram_mb     (video_ram_mb_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_window_x     (req_window_x),
      .req_window_y     (req_window_y),
      .req_source_width (req_source_width),
      .req_source_height(req_source_height),
      .req_scaled_width (req_scaled_width),
      .req_scaled_height(req_scaled_height),
      .req_pixel_format (req_pixel_format),
      .req_frame_bytes  (req_frame_bytes),
      .req_frame_count  (req_frame_count),
      .req_line_count   (req_line_count),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_push_data)
   );

   // two-entry queue of classified requests
   osrs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .empty    (q_empty)
   );

   // inverse scale factors, one quotient bit per cycle
   osrs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quotient)
   );

   // back: scale math, chroma origin state and the write sequence
   osrs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .is_newer_chip (is_newer_chip_ff),
      .q_empty       (q_empty),
      .q_data        (q_pop_data),
      .q_pop         (q_pop),
      .div_start     (div_start),
      .div_dividend  (div_dividend),
      .div_divisor   (div_divisor),
      .div_done      (div_done),
      .div_quotient  (div_quotient),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_reg_offset(rsp_reg_offset),
      .rsp_reg_value (rsp_reg_value),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

endmodule

// File: sv/osrs_front.sv
module osrs_front #(
   parameter int MAX_FRAME_BYTES = osrs_pkg::MAX_FRAME_BYTES_DEF,
   parameter int MAX_FRAMES      = osrs_pkg::MAX_FRAMES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [6:0]         video_ram_mb,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [11:0] req_window_x,
   input  logic signed [11:0] req_window_y,
   input  logic [10:0]        req_source_width,
   input  logic [10:0]        req_source_height,
   input  logic [10:0]        req_scaled_width,
   input  logic [10:0]        req_scaled_height,
   input  logic [1:0]         req_pixel_format,
   input  logic [20:0]        req_frame_bytes,
   input  logic [2:0]         req_frame_count,
   input  logic [11:0]        req_line_count,
   input  logic               q_full,
   output logic               q_push,
   output osrs_pkg::desc_type q_data
);

   logic               hold_valid_ff, hold_valid_in;
   osrs_pkg::desc_type hold_ff, hold_in;
   logic               accept;
   logic [23:0]        need;
   logic [26:0]        mem_bytes;
   logic [26:0]        room;

   assign req_stall = hold_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = hold_valid_ff && !q_full;
   assign q_data    = hold_ff;

   assign need      = 24'(req_frame_count) * 24'(req_frame_bytes);
   assign mem_bytes = {video_ram_mb, 20'd0};
   assign room      = mem_bytes - 27'(need);

   always_comb begin
      hold_valid_in = accept ? 1'b1 : (q_push ? 1'b0 : hold_valid_ff);
      hold_in       = hold_ff;
      if (accept) begin
         hold_in.window_x      = req_window_x;
         hold_in.window_y      = req_window_y;
         hold_in.source_width  = req_source_width;
         hold_in.source_height = req_source_height;
         hold_in.scaled_width  = req_scaled_width;
         hold_in.scaled_height = req_scaled_height;
         hold_in.pixel_format  = req_pixel_format;
         hold_in.frame_bytes   = req_frame_bytes;
         hold_in.line_count    = req_line_count;
         hold_in.base          = {5'd0, room[26:16], 16'd0};
         if (req_frame_bytes == 21'd0 || req_frame_bytes > 21'(MAX_FRAME_BYTES)) begin
            hold_in.status = osrs_pkg::ST_FRAME_SIZE;
         end else if (req_frame_count == 3'd0 || req_frame_count > 3'(MAX_FRAMES)) begin
            hold_in.status = osrs_pkg::ST_COUNT;
         end else if (mem_bytes < 27'(need)) begin
            hold_in.status = osrs_pkg::ST_NO_MEMORY;
         end else if (req_pixel_format > osrs_pkg::FMT_PACKED) begin
            hold_in.status = osrs_pkg::ST_FORMAT;
         end else if (req_scaled_width <= 11'd1 || req_scaled_height <= 11'd1) begin
            hold_in.status = osrs_pkg::ST_DIVIDE;
         end else begin
            hold_in.status = osrs_pkg::ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

endmodule

// File: sv/osrs_queue.sv
module osrs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  osrs_pkg::desc_type push_data,
   output logic               full,
   input  logic               pop,
   output osrs_pkg::desc_type pop_data,
   output logic               empty
);

   osrs_pkg::desc_type mem_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign full     = count_ff == 2'd2;
   assign empty    = count_ff == 2'd0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/osrs_div.sv
module osrs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [10:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] quo_ff, quo_in;
   logic [10:0] rem_ff, rem_in;
   logic [10:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic [11:0] shifted;
   logic        fits;

   assign done     = done_ff;
   assign quotient = quo_ff;
   assign shifted  = {rem_ff, quo_ff[31]};
   assign fits     = shifted >= {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = 11'd0;
         dvs_in = divisor;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         // one restoring step per cycle
         rem_in  = fits ? 11'(shifted - {1'b0, dvs_ff}) : shifted[10:0];
         quo_in  = {quo_ff[30:0], fits};
         cnt_in  = cnt_ff - 6'd1;
         done_in = cnt_ff == 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 6'd0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

// File: sv/osrs_back.sv
module osrs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               is_newer_chip,
   input  logic               q_empty,
   input  osrs_pkg::desc_type q_data,
   output logic               q_pop,
   output logic               div_start,
   output logic [31:0]        div_dividend,
   output logic [10:0]        div_divisor,
   input  logic               div_done,
   input  logic [31:0]        div_quotient,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [13:0]        rsp_reg_offset,
   output logic [31:0]        rsp_reg_value,
   output logic [2:0]         rsp_status,
   output logic               rsp_last
);

   typedef enum logic [2:0] {
      IDLE, PREP, WAIT_H, WAIT_V, CALC1, CALC2, CALC3, EMIT
   } state_type;

   localparam logic [4:0] SLOT_CTL         = 5'd0;
   localparam logic [4:0] SLOT_PITCH       = 5'd2;
   localparam logic [4:0] SLOT_ORG_FIRST   = 5'd3;
   localparam logic [4:0] SLOT_ORG_LAST    = 5'd10;
   localparam logic [4:0] SLOT_C3ORG_FIRST = 5'd11;
   localparam logic [4:0] SLOT_HCOORD      = 5'd15;
   localparam logic [4:0] SLOT_FINAL       = 5'd26;

   state_type          state_ff, state_in;
   osrs_pkg::desc_type d_ff, d_in;
   logic [4:0]         e_ff, e_in;
   logic [31:0]        hif_ff, hif_in, vif_ff, vif_in;
   logic [31:0]        hsrcst_ff, hsrcst_in, hsrcend_ff, hsrcend_in;
   logic [31:0]        prod_ff, prod_in, wt_ff, wt_in;
   logic [22:0]        plane_ff, plane_in;
   logic [27:0]        lofs_ff, lofs_in;
   logic [26:0]        cofs_ff, cofs_in;
   logic [31:0]        chroma_ff [8];
   logic [31:0]        chroma_in [8];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [13:0]        rsp_offset_ff, rsp_offset_in;
   logic [31:0]        rsp_value_ff, rsp_value_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic [31:0]        x_ext, y_ext;
   logic [10:0]        left, top;
   logic [11:0]        ofsleft, ofstop;
   logic [11:0]        pitch;
   logic [31:0]        hcoord, vcoord, srclst, wght;
   logic [43:0]        p_hst;
   logic [43:0]        p_vp;
   logic [41:0]        p_wt;
   logic [31:0]        span;
   logic [63:0]        p_hend;
   logic [4:0]         sel;
   logic [1:0]         k;
   logic [31:0]        kf, a_val;
   logic [31:0]        slot_value;
   logic [13:0]        slot_offset;
   logic [4:0]         e_next;

   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_offset = rsp_offset_ff;
   assign rsp_reg_value  = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last       = rsp_last_ff;

   // window geometry
   assign x_ext   = {{20{d_ff.window_x[11]}}, d_ff.window_x};
   assign y_ext   = {{20{d_ff.window_y[11]}}, d_ff.window_y};
   assign left    = d_ff.window_x[11] ? 11'd0 : d_ff.window_x[10:0];
   assign top     = d_ff.window_y[11] ? 11'd0 : d_ff.window_y[10:0];
   assign ofsleft = d_ff.window_x[11] ? 12'(-d_ff.window_x) : 12'd0;
   assign ofstop  = d_ff.window_y[11] ? 12'(-d_ff.window_y) : 12'd0;
   assign pitch   = 12'((13'(d_ff.source_width) + 13'd31) & ~13'd31);
   assign hcoord  = {5'd0, left, 16'd0} + (x_ext + 32'(d_ff.scaled_width) - 32'd1);
   assign vcoord  = {5'd0, top, 16'd0} + (y_ext + 32'(d_ff.scaled_height) - 32'd1);
   assign srclst  = 32'(d_ff.source_height) - 32'd1 - {22'd0, prod_ff[25:16]};
   assign wght    = {15'd0, wt_ff[31], wt_ff[13:0], 2'd0};

   // products, one stage each
   assign p_hst  = 44'(ofsleft) * 44'(hif_ff);
   assign p_vp   = 44'(ofstop) * 44'(vif_ff);
   assign p_wt   = 42'(ofstop) * 42'(vif_ff[29:0]);
   assign span   = 32'(d_ff.scaled_width) - 32'(ofsleft) - 32'd1;
   assign p_hend = 64'(span) * 64'(hif_ff);

   // buffer origins during emission
   assign sel   = e_ff - SLOT_ORG_FIRST;
   assign k     = sel[2:1];
   assign kf    = 32'(d_ff.frame_bytes) * 32'(k);
   assign a_val = d_ff.base + 32'(lofs_ff) + kf;

   always_comb begin
      slot_offset = osrs_pkg::OFS_CTL;
      slot_value  = '0;
      if (e_ff >= SLOT_ORG_FIRST && e_ff <= SLOT_ORG_LAST) begin
         if (sel[0]) begin
            slot_offset = osrs_pkg::OFS_CORG_BASE + {10'd0, k, 2'd0};
            slot_value  = chroma_ff[{1'b0, k}];
         end else begin
            slot_offset = osrs_pkg::OFS_ORG_BASE + {10'd0, k, 2'd0};
            slot_value  = a_val;
         end
      end else if (e_ff >= SLOT_C3ORG_FIRST && e_ff < SLOT_HCOORD) begin
         slot_offset = osrs_pkg::OFS_C3ORG_BASE + {10'd0, sel[1:0] ^ 2'd0, 2'd0};
         slot_value  = chroma_ff[{1'b1, sel[1:0]}];
      end else begin
         case (e_ff)
            5'd0: begin
               slot_offset = osrs_pkg::OFS_CTL;
               slot_value  = osrs_pkg::CTL_BASE |
                  ((d_ff.pixel_format == osrs_pkg::FMT_PLANAR) ? osrs_pkg::CTL_PLANAR : 32'd0);
            end
            5'd1: begin
               slot_offset = osrs_pkg::OFS_LUMA_CTL;
               slot_value  = osrs_pkg::LUMA_CTL_VAL;
            end
            5'd2: begin
               slot_offset = osrs_pkg::OFS_PITCH;
               slot_value  = 32'(pitch);
            end
            5'd15: begin
               slot_offset = osrs_pkg::OFS_HCOORD;
               slot_value  = hcoord;
            end
            5'd16: begin
               slot_offset = osrs_pkg::OFS_HISCAL;
               slot_value  = {hif_ff[29:0], 2'd0};
            end
            5'd17: begin
               slot_offset = osrs_pkg::OFS_HSRCST;
               slot_value  = hsrcst_ff;
            end
            5'd18: begin
               slot_offset = osrs_pkg::OFS_HSRCEND;
               slot_value  = hsrcend_ff;
            end
            5'd19: begin
               slot_offset = osrs_pkg::OFS_HSRCLST;
               slot_value  = {16'(32'(d_ff.source_width) - 32'd1), 16'd0};
            end
            5'd20: begin
               slot_offset = osrs_pkg::OFS_VCOORD;
               slot_value  = vcoord;
            end
            5'd21: begin
               slot_offset = osrs_pkg::OFS_VISCAL;
               slot_value  = {vif_ff[29:0], 2'd0};
            end
            5'd22: begin
               slot_offset = osrs_pkg::OFS_V1SRCLST;
               slot_value  = srclst;
            end
            5'd23: begin
               slot_offset = osrs_pkg::OFS_V1WGHT;
               slot_value  = wght;
            end
            5'd24: begin
               slot_offset = osrs_pkg::OFS_V2SRCLST;
               slot_value  = srclst;
            end
            5'd25: begin
               slot_offset = osrs_pkg::OFS_V2WGHT;
               slot_value  = wght;
            end
            5'd26: begin
               slot_offset = osrs_pkg::OFS_GLOBAL;
               slot_value  = osrs_pkg::GLOBAL_BASE +
                  {3'd0, 13'(d_ff.line_count) + 13'd2, 16'd0};
            end
            default: begin
               slot_offset = osrs_pkg::OFS_CTL;
               slot_value  = '0;
            end
         endcase
      end
   end

   // older chip skips luma control and third-plane origins
   always_comb begin
      if (e_ff == SLOT_CTL && !is_newer_chip) begin
         e_next = SLOT_PITCH;
      end else if (e_ff == SLOT_ORG_LAST && !is_newer_chip) begin
         e_next = SLOT_HCOORD;
      end else begin
         e_next = e_ff + 5'd1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      d_in          = d_ff;
      e_in          = e_ff;
      hif_in        = hif_ff;
      vif_in        = vif_ff;
      hsrcst_in     = hsrcst_ff;
      hsrcend_in    = hsrcend_ff;
      prod_in       = prod_ff;
      wt_in         = wt_ff;
      plane_in      = plane_ff;
      lofs_in       = lofs_ff;
      cofs_in       = cofs_ff;
      chroma_in     = chroma_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_offset_in = rsp_offset_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      div_start     = 1'b0;
      div_dividend  = {18'(32'(d_ff.source_width) - 32'd1), 14'd0};
      div_divisor   = d_ff.scaled_width - 11'd1;
      case (state_ff)
         IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               d_in     = q_data;
               state_in = PREP;
            end
         end
         PREP: begin
            if (d_ff.status != osrs_pkg::ST_OK) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_offset_in = '0;
                  rsp_value_in  = '0;
                  rsp_status_in = d_ff.status;
                  rsp_last_in   = 1'b1;
                  state_in      = IDLE;
               end
            end else begin
               div_start = 1'b1;
               state_in  = WAIT_H;
            end
         end
         WAIT_H: begin
            if (div_done) begin
               hif_in       = div_quotient;
               div_start    = 1'b1;
               div_dividend = {18'(32'(d_ff.source_height) - 32'd1), 14'd0};
               div_divisor  = d_ff.scaled_height - 11'd1;
               state_in     = WAIT_V;
            end
         end
         WAIT_V: begin
            if (div_done) begin
               vif_in   = div_quotient;
               state_in = CALC1;
            end
         end
         CALC1: begin
            hsrcst_in = {p_hst[29:0], 2'd0};
            prod_in   = {p_vp[29:0], 2'd0};
            wt_in     = p_wt[31:0];
            plane_in  = 23'(pitch) * 23'(d_ff.source_height);
            state_in  = CALC2;
         end
         CALC2: begin
            hsrcend_in = hsrcst_ff + {p_hend[29:0], 2'd0};
            lofs_in    = 28'(prod_ff[31:16]) * 28'(pitch);
            cofs_in    = is_newer_chip ? 27'(prod_ff[31:18]) * 27'(pitch)
                                       : 27'(prod_ff[31:17]) * 27'(pitch);
            state_in   = CALC3;
         end
         CALC3: begin
            if (d_ff.pixel_format == osrs_pkg::FMT_PLANAR) begin
               for (int i = 0; i < 4; i++) begin
                  chroma_in[i] = d_ff.base + 32'(cofs_ff) +
                     32'(d_ff.frame_bytes) * 32'(i) + 32'(plane_ff);
                  chroma_in[4 + i] = d_ff.base + 32'(cofs_ff) +
                     32'(d_ff.frame_bytes) * 32'(i) + 32'(plane_ff) + 32'(plane_ff[22:2]);
               end
            end
            e_in     = SLOT_CTL;
            state_in = EMIT;
         end
         EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = slot_offset;
               rsp_value_in  = slot_value;
               rsp_status_in = osrs_pkg::ST_OK;
               rsp_last_in   = e_ff == SLOT_FINAL;
               if (e_ff == SLOT_FINAL) begin
                  state_in = IDLE;
               end else begin
                  e_in = e_next;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            chroma_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chroma_ff    <= chroma_in;
      end
      d_ff          <= d_in;
      e_ff          <= e_in;
      hif_ff        <= hif_in;
      vif_ff        <= vif_in;
      hsrcst_ff     <= hsrcst_in;
      hsrcend_ff    <= hsrcend_in;
      prod_ff       <= prod_in;
      wt_ff         <= wt_in;
      plane_ff      <= plane_in;
      lofs_ff       <= lofs_in;
      cofs_ff       <= cofs_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

// File: dv/overlay_scaler_register_setup_tb.sv
module overlay_scaler_register_setup_tb;

   // one overlay window request as the driver presents it
   typedef struct {
      logic [11:0] wx;
      logic [11:0] wy;
      logic [10:0] sw;
      logic [10:0] sh;
      logic [10:0] dw;
      logic [10:0] dh;
      logic [1:0]  fmt;
      logic [20:0] fbytes;
      logic [2:0]  fcount;
      logic [11:0] lines;
   } window_req_type;

   // one scaler register write (or error) as it leaves the block
   typedef struct {
      logic [13:0] offset;
      logic [31:0] value;
      logic [2:0]  status;
      logic        last;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        csr_write = 1'b0;
   logic        csr_index = osrs_pkg::CSR_IS_NEWER_CHIP;
   logic [6:0]  csr_data = '0;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [11:0] req_window_x = '0;
   logic signed [11:0] req_window_y = '0;
   logic [10:0]        req_source_width = 11'd1;
   logic [10:0]        req_source_height = 11'd1;
   logic [10:0]        req_scaled_width = 11'd2;
   logic [10:0]        req_scaled_height = 11'd2;
   logic [1:0]         req_pixel_format = osrs_pkg::FMT_PLANAR;
   logic [20:0]        req_frame_bytes = 21'd1;
   logic [2:0]         req_frame_count = 3'd1;
   logic [11:0]        req_line_count = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [13:0] rsp_reg_offset;
   logic [31:0] rsp_reg_value;
   logic [2:0]  rsp_status;
   logic        rsp_last;

   overlay_scaler_register_setup dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_window_x(req_window_x), .req_window_y(req_window_y),
      .req_source_width(req_source_width), .req_source_height(req_source_height),
      .req_scaled_width(req_scaled_width), .req_scaled_height(req_scaled_height),
      .req_pixel_format(req_pixel_format), .req_frame_bytes(req_frame_bytes),
      .req_frame_count(req_frame_count), .req_line_count(req_line_count),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_reg_offset(rsp_reg_offset), .rsp_reg_value(rsp_reg_value),
      .rsp_status(rsp_status), .rsp_last(rsp_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor copy of the csrs and the chroma origin store
   logic        newer_chip = 1'b0;
   logic [6:0]  vram_mb = 7'd16;
   logic [31:0] chroma_org [8];

   window_req_type pending_reqs[$];
   reg_write_type  expected_writes[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int n_accepted = 0;
   int n_writes = 0;
   int n_errors_seen = 0;
   int n_fail = 0;
   bit stim_done = 1'b0;

   // add one register write to the expected stream
   task automatic push_write(input logic [13:0] ofs, input logic [31:0] val);
      reg_write_type w;
      w.offset = ofs;
      w.value = val;
      w.status = osrs_pkg::ST_OK;
      w.last = 1'b0;
      expected_writes.push_back(w);
   endtask

   task automatic push_error(input logic [2:0] code);
      reg_write_type w;
      w.offset = '0;
      w.value = '0;
      w.status = code;
      w.last = 1'b1;
      expected_writes.push_back(w);
   endtask

   // compute the write sequence one accepted request produces
   task automatic predict_scaler_writes(input window_req_type r);
      int signed x, y, left, top, ofsleft, ofstop;
      longint room;
      logic [31:0] base, ctl, pitch, hif, vif, hiscal, viscal, hsrcst, hsrcend;
      logic [31:0] hcoord, vcoord, prod, lofs, wt, wght, srclst, cofs, plane;
      logic [31:0] sw, sh, dw, dh, fb;
      logic [31:0] luma_org [4];
      reg_write_type w;
      x = $signed(r.wx);
      y = $signed(r.wy);
      sw = r.sw; sh = r.sh; dw = r.dw; dh = r.dh; fb = r.fbytes;
      if (r.fbytes == 0 || r.fbytes > osrs_pkg::MAX_FRAME_BYTES_DEF) begin
         push_error(osrs_pkg::ST_FRAME_SIZE);
         return;
      end
      if (r.fcount < 1 || r.fcount > osrs_pkg::MAX_FRAMES_DEF) begin
         push_error(osrs_pkg::ST_COUNT);
         return;
      end
      room = longint'(vram_mb) * 64'h100000 - longint'(r.fcount) * longint'(r.fbytes);
      if (room < 0) begin
         push_error(osrs_pkg::ST_NO_MEMORY);
         return;
      end
      base = room[31:0] & 32'hFFFF_0000;
      if (r.fmt > osrs_pkg::FMT_PACKED) begin
         push_error(osrs_pkg::ST_FORMAT);
         return;
      end
      if (dw <= 1 || dh <= 1) begin
         push_error(osrs_pkg::ST_DIVIDE);
         return;
      end
      ctl = osrs_pkg::CTL_BASE;
      if (r.fmt == osrs_pkg::FMT_PLANAR) ctl = ctl + osrs_pkg::CTL_PLANAR;
      left = (x > 0) ? x : 0;
      top = (y > 0) ? y : 0;
      hcoord = (32'(left) << 16) + 32'(x + int'(dw) - 1);
      vcoord = (32'(top) << 16) + 32'(y + int'(dh) - 1);
      pitch = (sw + 32'd31) & ~32'd31;
      hif = ((sw - 1) << 14) / (dw - 1);
      ofsleft = left - x;
      hiscal = hif << 2;
      hsrcst = (32'(ofsleft) * hif) << 2;
      hsrcend = hsrcst + ((32'(int'(dw) - ofsleft - 1) * hif) << 2);
      vif = ((sh - 1) << 14) / (dh - 1);
      ofstop = top - y;
      viscal = vif << 2;
      prod = 32'(ofstop) * viscal;
      lofs = (prod >> 16) * pitch;
      for (int k = 0; k < 4; k++) luma_org[k] = base + lofs + 32'(k) * fb;
      if (r.fmt == osrs_pkg::FMT_PLANAR) begin
         cofs = (newer_chip ? (prod / 4) : (prod / 2)) >> 16;
         plane = pitch * sh;
         cofs = cofs * pitch;
         for (int k = 0; k < 4; k++) begin
            chroma_org[k] = base + cofs + 32'(k) * fb + plane;
            chroma_org[4 + k] = chroma_org[k] + plane / 4;
         end
      end
      wt = 32'(ofstop) * (viscal >> 2);
      wght = ((wt >> 31) << 16) + ((wt & 32'h3FFF) << 2);
      srclst = sh - 1 - ((prod >> 16) & 32'h3FF);

      push_write(osrs_pkg::OFS_CTL, ctl);
      if (newer_chip) push_write(osrs_pkg::OFS_LUMA_CTL, osrs_pkg::LUMA_CTL_VAL);
      push_write(osrs_pkg::OFS_PITCH, pitch);
      for (int k = 0; k < 4; k++) begin
         push_write(osrs_pkg::OFS_ORG_BASE + 14'(4 * k), luma_org[k]);
         push_write(osrs_pkg::OFS_CORG_BASE + 14'(4 * k), chroma_org[k]);
      end
      if (newer_chip)
         for (int k = 0; k < 4; k++)
            push_write(osrs_pkg::OFS_C3ORG_BASE + 14'(4 * k), chroma_org[4 + k]);
      push_write(osrs_pkg::OFS_HCOORD, hcoord);
      push_write(osrs_pkg::OFS_HISCAL, hiscal);
      push_write(osrs_pkg::OFS_HSRCST, hsrcst);
      push_write(osrs_pkg::OFS_HSRCEND, hsrcend);
      push_write(osrs_pkg::OFS_HSRCLST, (sw - 1) << 16);
      push_write(osrs_pkg::OFS_VCOORD, vcoord);
      push_write(osrs_pkg::OFS_VISCAL, viscal);
      push_write(osrs_pkg::OFS_V1SRCLST, srclst);
      push_write(osrs_pkg::OFS_V1WGHT, wght);
      push_write(osrs_pkg::OFS_V2SRCLST, srclst);
      push_write(osrs_pkg::OFS_V2WGHT, wght);
      // final global control write carries the last flag
      w.offset = osrs_pkg::OFS_GLOBAL;
      w.value = osrs_pkg::GLOBAL_BASE + ((32'(r.lines) + 32'd2) << 16);
      w.status = osrs_pkg::ST_OK;
      w.last = 1'b1;
      expected_writes.push_back(w);
   endtask

   // driver: present the head of the pending queue, drop it once accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_scaler_writes(pending_reqs.pop_front());
            n_accepted++;
         end
         // a request stays up while stalled; otherwise pick the next one or idle
         if (!(req_valid && req_stall)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_window_x <= pending_reqs[0].wx;
               req_window_y <= pending_reqs[0].wy;
               req_source_width <= pending_reqs[0].sw;
               req_source_height <= pending_reqs[0].sh;
               req_scaled_width <= pending_reqs[0].dw;
               req_scaled_height <= pending_reqs[0].dh;
               req_pixel_format <= pending_reqs[0].fmt;
               req_frame_bytes <= pending_reqs[0].fbytes;
               req_frame_count <= pending_reqs[0].fcount;
               req_line_count <= pending_reqs[0].lines;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compare each accepted write against the oldest expectation
   always @(posedge clock) begin
      reg_write_type e;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_writes.size() == 0) begin
               $error("unexpected write: offset %h value %h status %0d",
                      rsp_reg_offset, rsp_reg_value, rsp_status);
               n_fail++;
            end else begin
               e = expected_writes.pop_front();
               n_writes++;
               if (rsp_status != osrs_pkg::ST_OK) n_errors_seen++;
               if (rsp_reg_offset !== e.offset) begin
                  $error("reg_offset: expected %h actual %h", e.offset, rsp_reg_offset);
                  n_fail++;
               end
               if (rsp_reg_value !== e.value) begin
                  $error("reg_value: expected %h actual %h", e.value, rsp_reg_value);
                  n_fail++;
               end
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d actual %0d", e.status, rsp_status);
                  n_fail++;
               end
               if (rsp_last !== e.last) begin
                  $error("last: expected %0d actual %0d", e.last, rsp_last);
                  n_fail++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // build a request; planar/packed well-formed mostly, noisy sometimes
   function automatic window_req_type random_req();
      window_req_type r;
      int pick;
      r.wx = $urandom_range(7) == 0 ? 12'($urandom) : 12'($urandom_range(300) - 100);
      r.wy = $urandom_range(7) == 0 ? 12'($urandom) : 12'($urandom_range(300) - 100);
      r.sw = $urandom_range(7) == 0 ? 11'($urandom) : 11'($urandom_range(1, 800));
      r.sh = $urandom_range(7) == 0 ? 11'($urandom) : 11'($urandom_range(1, 600));
      r.dw = $urandom_range(7) == 0 ? 11'($urandom) : 11'($urandom_range(2, 1200));
      r.dh = $urandom_range(7) == 0 ? 11'($urandom) : 11'($urandom_range(2, 900));
      r.fmt = 2'($urandom_range(1));
      r.fbytes = 21'($urandom_range(1, 400000));
      r.fcount = 3'($urandom_range(1, 4));
      r.lines = 12'($urandom);
      pick = $urandom_range(99);
      // noise: any format, frame size and count the ports allow, scaled width only 0..3
      if (pick < 12) begin
         r.fmt = 2'($urandom);
         r.fbytes = 21'($urandom);
         r.fcount = 3'($urandom);
         r.dw = 11'($urandom_range(3));
         r.dh = 11'($urandom_range(2047));
      end else if (pick < 20) begin
         r.fbytes = 21'($urandom_range(1, osrs_pkg::MAX_FRAME_BYTES_DEF));
      end
      return r;
   endfunction

   task automatic add_req(input int x, input int y, input int sw, input int sh,
                          input int dw, input int dh, input int fmt, input int fb,
                          input int fc, input int ln);
      window_req_type r;
      r.wx = 12'(x); r.wy = 12'(y); r.sw = 11'(sw); r.sh = 11'(sh);
      r.dw = 11'(dw); r.dh = 11'(dh); r.fmt = 2'(fmt); r.fbytes = 21'(fb);
      r.fcount = 3'(fc); r.lines = 12'(ln);
      pending_reqs.push_back(r);
   endtask

   // wait for the block to drain
   task automatic wait_quiet();
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_writes.size() == 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [6:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      // predictor follows the register at the edge it is taken
      if (idx == osrs_pkg::CSR_IS_NEWER_CHIP) newer_chip = val[0];
      else vram_mb = val;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int k = 0; k < 8; k++) chroma_org[k] = '0;

      // directed: packed first so the cleared chroma store is read, then edge cases and error paths
      add_req(0, 0, 320, 240, 640, 480, osrs_pkg::FMT_PACKED, 153600, 2, 100);
      add_req(-2048, -2048, 2047, 2047, 2047, 2047, osrs_pkg::FMT_PLANAR, 1572864, 1, 4095);
      add_req(2047, 2047, 1, 1, 2, 2, osrs_pkg::FMT_PLANAR, 1, 4, 0);
      add_req(-100, -50, 720, 576, 360, 288, osrs_pkg::FMT_PLANAR, 622080, 4, 10);
      add_req(10, 10, 720, 576, 1024, 768, osrs_pkg::FMT_PACKED, 829440, 1, 20);
      add_req(0, 0, 100, 100, 100, 100, osrs_pkg::FMT_PLANAR, 0, 1, 0);
      add_req(0, 0, 100, 100, 100, 100, osrs_pkg::FMT_PLANAR, 1572865, 1, 0);
      add_req(0, 0, 100, 100, 100, 100, osrs_pkg::FMT_PLANAR, 2097151, 7, 0);
      add_req(0, 0, 100, 100, 100, 100, osrs_pkg::FMT_PLANAR, 1000, 0, 0);
      add_req(0, 0, 100, 100, 100, 100, osrs_pkg::FMT_PLANAR, 1000, 5, 0);
      add_req(0, 0, 100, 100, 100, 100, osrs_pkg::FMT_PLANAR, 1572864, 4, 0);
      add_req(0, 0, 100, 100, 100, 100, 2, 1000, 1, 0);
      add_req(0, 0, 100, 100, 100, 100, 3, 1000, 1, 0);
      add_req(0, 0, 100, 100, 1, 100, osrs_pkg::FMT_PLANAR, 1000, 1, 0);
      add_req(0, 0, 100, 100, 100, 0, osrs_pkg::FMT_PLANAR, 1000, 1, 0);
      add_req(0, 0, 100, 100, 0, 1, osrs_pkg::FMT_PACKED, 1000, 1, 0);
      add_req(-1, -1, 1024, 768, 2, 2, osrs_pkg::FMT_PLANAR, 786432, 2, 4000);
      wait_quiet();

      // newer chip, directed planar and packed requests with 64 MiB
      write_csr(osrs_pkg::CSR_IS_NEWER_CHIP, 7'd1);
      write_csr(osrs_pkg::CSR_VIDEO_RAM_MB, 7'd64);
      add_req(-300, -200, 640, 480, 800, 600, osrs_pkg::FMT_PLANAR, 460800, 4, 1);
      add_req(5, 5, 640, 480, 800, 600, osrs_pkg::FMT_PACKED, 614400, 3, 2);
      add_req(-1, 0, 2047, 2047, 3, 3, osrs_pkg::FMT_PLANAR, 1572864, 4, 3);
      wait_quiet();

      // no video memory at all: every in-range request runs out of room
      write_csr(osrs_pkg::CSR_VIDEO_RAM_MB, 7'd0);
      add_req(0, 0, 64, 64, 64, 64, osrs_pkg::FMT_PLANAR, 1, 1, 0);
      add_req(0, 0, 64, 64, 64, 64, 2, 1, 1, 0);
      wait_quiet();

      // random phases with the idling mixes, settings changed between them
      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 53; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 53; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         write_csr(osrs_pkg::CSR_IS_NEWER_CHIP, 7'($urandom));
         write_csr(osrs_pkg::CSR_VIDEO_RAM_MB,
                   phase == 5 ? 7'd127 : 7'($urandom_range(1, 64)));
         for (int i = 0; i < 30; i++) pending_reqs.push_back(random_req());
         // sender holds off mid-phase until everything is back
         if (phase == 2) begin
            wait (pending_reqs.size() == 0 && !req_valid);
            wait (expected_writes.size() == 0);
            for (int i = 0; i < 5; i++) pending_reqs.push_back(random_req());
         end
         wait_quiet();
      end
      stim_done = 1'b1;
   end

   initial begin
      wait (stim_done);
      $display("requests accepted: %0d, register writes checked: %0d, error results: %0d",
               n_accepted, n_writes, n_errors_seen);
      $display("covered both chip variants, memory sizes 0..127, all error codes, clipping");
      if (n_fail == 0)
         $display("overlay_scaler_register_setup_tb passed");
      else
         $display("overlay_scaler_register_setup_tb failed");
      $finish;
   end

   // watchdog: far beyond the slowest legitimate run
   initial begin
      #4000000;
      $display("overlay_scaler_register_setup_tb failed");
      $finish;
   end

endmodule

// File: overlay_scaler_register_setup.f
sv/osrs_pkg.sv
sv/osrs_front.sv
sv/osrs_queue.sv
sv/osrs_div.sv
sv/osrs_back.sv
sv/overlay_scaler_register_setup.sv
dv/overlay_scaler_register_setup_tb.sv
